### hdl/mrc_pkg.sv
package mrc_pkg;

  localparam int NUM_DIMS   = 4;
  localparam int COORD_W    = 8;
  localparam int EXT_W      = COORD_W + 1;
  localparam int LIN_W      = 32;
  localparam int ORDER_W    = 3;
  localparam int DIM_W      = 2;
  localparam int STEP_BITS  = 8;
  localparam int CHUNKS     = LIN_W / STEP_BITS;
  localparam int NUM_STAGES = NUM_DIMS * CHUNKS;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [ORDER_W-1:0] MAX_ORDER_C = ORDER_W'(NUM_DIMS);
  localparam logic [EXT_W-1:0]   EXT_MAX_C   = EXT_W'(1) << COORD_W;

  typedef enum logic [2:0] {
    REG_ORDER = 3'd0,
    REG_EXT_0 = 3'd1,
    REG_EXT_1 = 3'd2,
    REG_EXT_2 = 3'd3,
    REG_EXT_3 = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_FOLD   = 1'b0,
    OP_UNFOLD = 1'b1
  } op_e;

  // Saturated configuration as the datapath sees it
  typedef struct packed {
    logic [ORDER_W-1:0]                n;
    logic [NUM_DIMS-1:0][EXT_W-1:0]    ext;
  } cfg_t;

  typedef struct packed {
    logic                              op;
    logic                              bad;
    logic [LIN_W-1:0]                  acc;
    logic [EXT_W-1:0]                  rem;
    logic [NUM_DIMS-1:0][COORD_W-1:0]  cin;
    logic [NUM_DIMS-1:0][COORD_W-1:0]  cout;
  } stage_t;

endpackage

### hdl/mrc_stage.sv
module mrc_stage
  import mrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic [DIM_W-1:0] slot_i,
  input  logic [1:0]       chunk_i,
  input  logic             vld_i,
  input  stage_t           stg_i,
  output logic             vld_o,
  output stage_t           stg_o
);

  stage_t                   stg_d;
  stage_t                   stg_q;
  logic                     vld_q;
  logic                     active;
  logic [ORDER_W-1:0]       kd;
  logic [EXT_W-1:0]         ef;
  logic [EXT_W-1:0]         eb;
  logic [LIN_W+EXT_W-1:0]   prod;
  logic [EXT_W-1:0]         r;
  logic [LIN_W-1:0]         q;

  always_comb begin
    stg_d  = stg_i;
    active = {1'b0, slot_i} < cfg_i.n;
    kd     = cfg_i.n - ORDER_W'(1) - {1'b0, slot_i};
    ef     = cfg_i.ext[slot_i];
    eb     = cfg_i.ext[kd[DIM_W-1:0]];
    prod   = '0;
    r      = '0;
    q      = stg_i.acc;
    if (stg_i.op == OP_FOLD) begin
      // Horner step: acc = acc * extent + coord
      if (active && chunk_i == 2'd0) begin
        if ({1'b0, stg_i.cin[slot_i]} >= ef) begin
          stg_d.bad = 1'b1;
        end
        prod      = stg_i.acc * ef + (LIN_W+EXT_W)'(stg_i.cin[slot_i]);
        stg_d.acc = prod[LIN_W-1:0];
      end
    end else if (active) begin
      // Long division, eight quotient bits per stage, fastest dimension first
      if (eb == '0) begin
        stg_d.bad = 1'b1;
      end
      r = (chunk_i == 2'd0) ? '0 : stg_i.rem;
      for (int i = 0; i < STEP_BITS; i++) begin
        r = {r[EXT_W-2:0], q[LIN_W-1]};
        q = {q[LIN_W-2:0], 1'b0};
        if (r >= eb) begin
          r    = r - eb;
          q[0] = 1'b1;
        end
      end
      stg_d.acc = q;
      stg_d.rem = r;
      if (chunk_i == 2'(CHUNKS - 1)) begin
        stg_d.cout[kd[DIM_W-1:0]] = r[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

### hdl/mixed_radix_index_converter_top.sv
// Mixed-radix index converter: row-major tensor coordinate <-> linear offset.
//
// Request channel: drive start_i high with opcode_i and the operands; the
// request is taken at any rising edge where start_i is high and busy_o is
// low. busy_o stays low, so a new request may enter every clock cycle.
// Opcode fold (0) turns coord_in_0..3 into linear_out; opcode unfold (1)
// splits linear_in into coord_out_0..3. Unused dimensions read as zero;
// out_of_range_o flags an input outside the configured tensor and zeroes
// every other result field.
//
// Result channel: done_o pulses for one cycle with the result fields. The
// receiver cannot hold results off; results come back in request order.
// A request passes from the accepting edge through 16 pipeline stages
// (four per dimension, each resolving eight quotient bits of the long
// division; when folding, only the first of each four does a multiply-add)
// and the output register. Throughput is one request per cycle.
//
// Configuration goes through the APB port: order at 0x0, extents at
// 0x4..0x10. Write it only while no request is in flight. Reset clears all
// in-flight requests and sets order to 0 and every extent to 1.
module mixed_radix_index_converter_top
  import mrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                opcode_i,
  input  logic [LIN_W-1:0]    linear_in_i,
  input  logic [COORD_W-1:0]  coord_in_0_i,
  input  logic [COORD_W-1:0]  coord_in_1_i,
  input  logic [COORD_W-1:0]  coord_in_2_i,
  input  logic [COORD_W-1:0]  coord_in_3_i,
  output logic                done_o,
  output logic [LIN_W-1:0]    linear_out_o,
  output logic [COORD_W-1:0]  coord_out_0_o,
  output logic [COORD_W-1:0]  coord_out_1_o,
  output logic [COORD_W-1:0]  coord_out_2_o,
  output logic [COORD_W-1:0]  coord_out_3_o,
  output logic                out_of_range_o
);

  logic [ORDER_W-1:0]             order_q;
  logic [NUM_DIMS-1:0][EXT_W-1:0] ext_q;
  logic                           cfg_wr;
  reg_idx_e                       reg_idx;
  cfg_t                           cfg;

  logic   [NUM_STAGES:0] vld;
  stage_t [NUM_STAGES:0] stg;
  stage_t                head;

  stage_t                          fin;
  logic                            fin_bad;
  logic                            done_q;
  logic [LIN_W-1:0]                lin_q;
  logic [NUM_DIMS-1:0][COORD_W-1:0] crd_q;
  logic                            oor_q;

  assign pready  = 1'b1;
  assign busy_o  = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  // Register file; writes beyond the extent registers drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      ext_q   <= {NUM_DIMS{EXT_W'(1)}};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORDER: order_q  <= pwdata[ORDER_W-1:0];
        REG_EXT_0: ext_q[0] <= pwdata[EXT_W-1:0];
        REG_EXT_1: ext_q[1] <= pwdata[EXT_W-1:0];
        REG_EXT_2: ext_q[2] <= pwdata[EXT_W-1:0];
        REG_EXT_3: ext_q[3] <= pwdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER: prdata = DATA_W'(order_q);
      REG_EXT_0: prdata = DATA_W'(ext_q[0]);
      REG_EXT_1: prdata = DATA_W'(ext_q[1]);
      REG_EXT_2: prdata = DATA_W'(ext_q[2]);
      REG_EXT_3: prdata = DATA_W'(ext_q[3]);
      default:   prdata = '0;
    endcase
  end

  // Saturate order and extents before they reach the datapath
  always_comb begin
    cfg.n = (order_q > MAX_ORDER_C) ? MAX_ORDER_C : order_q;
    for (int k = 0; k < NUM_DIMS; k++) begin
      cfg.ext[k] = (ext_q[k] > EXT_MAX_C) ? EXT_MAX_C : ext_q[k];
    end
  end

  // Load the request into the head of the pipeline
  always_comb begin
    head.op      = opcode_i;
    head.bad     = 1'b0;
    head.acc     = (opcode_i == OP_UNFOLD) ? linear_in_i : '0;
    head.rem     = '0;
    head.cin[0]  = coord_in_0_i;
    head.cin[1]  = coord_in_1_i;
    head.cin[2]  = coord_in_2_i;
    head.cin[3]  = coord_in_3_i;
    head.cout    = '0;
  end

  assign vld[0] = start_i && !busy_o;
  assign stg[0] = head;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    mrc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg),
      .slot_i  (DIM_W'(s / CHUNKS)),
      .chunk_i (2'(s % CHUNKS)),
      .vld_i   (vld[s]),
      .stg_i   (stg[s]),
      .vld_o   (vld[s+1]),
      .stg_o   (stg[s+1])
    );
  end

  // After unfolding, a nonzero leftover quotient means the offset was
  // at or beyond the element count
  assign fin     = stg[NUM_STAGES];
  assign fin_bad = fin.bad || (fin.op == OP_UNFOLD && fin.acc != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[NUM_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    oor_q <= fin_bad;
    lin_q <= (fin_bad || fin.op == OP_UNFOLD) ? '0 : fin.acc;
    crd_q <= (fin_bad || fin.op == OP_FOLD) ? '0 : fin.cout;
  end

  assign done_o         = done_q;
  assign linear_out_o   = lin_q;
  assign coord_out_0_o  = crd_q[0];
  assign coord_out_1_o  = crd_q[1];
  assign coord_out_2_o  = crd_q[2];
  assign coord_out_3_o  = crd_q[3];
  assign out_of_range_o = oor_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, NUM_STAGES + 1))
    else $error("result without matching request");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (linear_out_o == '0 && coord_out_0_o == '0 &&
      coord_out_1_o == '0 && coord_out_2_o == '0 && coord_out_3_o == '0))
    else $error("out-of-range result carries nonzero fields");

  a_vld_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NUM_STAGES] |=> done_o)
    else $error("pipeline output lost");
`endif

endmodule
